// ----- rtl/upqs_pkg.sv -----
package upqs_pkg;

  // Default depth of the result queue; it must hold at least two entries.
  localparam int ResultDepth = 4;

  // Result kinds as seen on the kind port.
  localparam logic [2:0] KIND_PATH     = 3'd0;
  localparam logic [2:0] KIND_NAME     = 3'd1;
  localparam logic [2:0] KIND_VALUE    = 3'd2;
  localparam logic [2:0] KIND_PATH_END = 3'd3;
  localparam logic [2:0] KIND_PAIR_END = 3'd4;
  localparam logic [2:0] KIND_ERROR    = 3'd5;

  // One result beat.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       run_last;
  } result_t;

  // Results caused by one input byte: none, one (r0) or two (r0 then r1).
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } step_t;

endpackage

// ----- rtl/uri_percent_decode_query_split.sv -----
// Channel  Handshake             Beat payload
// in       in_valid / in_ready   in_byte, in_last
// out      out_valid / out_ready kind, data, run_last
//
// Each accepted byte is decoded in the cycle it is taken; its results enter the
// result queue in the next cycle and reach out once the beats ahead have left.
// One byte is taken per cycle while the queue has two free entries; a byte
// causes at most two result beats, which leave one per cycle while out_ready is high.
// Reset (rst, synchronous) returns the parser to the path and empties the queue.
// A stall on out fills the queue and then drops in_ready; nothing is lost.
module uri_percent_decode_query_split
  import upqs_pkg::*;
#(
  parameter int DEPTH = ResultDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] data,
  output logic       run_last
);

  step_t   res;
  result_t head;
  logic    space;
  logic    step;

  assign in_ready = space;
  assign step     = in_valid & space;

  // Byte parser.
  upqs_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte),
    .in_last (in_last),
    .res     (res)
  );

  // Result queue.
  upqs_result_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_res  (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign kind     = head.kind;
  assign data     = head.data;
  assign run_last = head.run_last;

endmodule

// ----- rtl/upqs_decode.sv -----
module upqs_decode
  import upqs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output step_t      res
);

  typedef enum logic [2:0] {
    PH_PATH,
    PH_ESC1,
    PH_ESC2,
    PH_QNAME,
    PH_QVALUE,
    PH_SKIP
  } phase_t;

  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharQmark   = 8'h3F;
  localparam logic [7:0] CharAmp     = 8'h26;
  localparam logic [7:0] CharEquals  = 8'h3D;

  phase_t     phase;
  phase_t     phase_mid;
  phase_t     phase_next;
  logic [3:0] high_nibble;
  logic [3:0] nib_mid;
  logic [3:0] nib_next;
  logic       pair_open;
  logic       pair_mid;
  logic       pair_next;
  logic       hex_ok;
  logic [3:0] hex_val;
  logic       a_v;
  logic [2:0] a_kind;
  logic [7:0] a_data;
  logic       b_v;
  logic [2:0] b_kind;

  // Hex digit recognition, either case.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte inside {[8'h30:8'h39]}) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte inside {[8'h61:8'h66]}) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte inside {[8'h41:8'h46]}) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Per-byte decoding: the result of the byte itself and the state it leaves.
  always_comb begin
    phase_mid = phase;
    nib_mid   = high_nibble;
    pair_mid  = pair_open;
    a_v       = 1'b0;
    a_kind    = KIND_PATH;
    a_data    = 8'h00;
    case (phase)
      PH_PATH: begin
        if (in_byte == CharPercent) begin
          phase_mid = PH_ESC1;
        end else if (in_byte == CharQmark) begin
          a_v       = 1'b1;
          a_kind    = KIND_PATH_END;
          phase_mid = PH_QNAME;
          pair_mid  = 1'b0;
        end else if (in_byte == CharPlus) begin
          a_v    = 1'b1;
          a_data = CharSpace;
        end else begin
          a_v    = 1'b1;
          a_data = in_byte;
        end
      end
      PH_ESC1: begin
        if (!hex_ok) begin
          a_v       = 1'b1;
          a_kind    = KIND_ERROR;
          phase_mid = PH_SKIP;
        end else begin
          nib_mid   = hex_val;
          phase_mid = PH_ESC2;
        end
      end
      PH_ESC2: begin
        a_v = 1'b1;
        if (!hex_ok) begin
          a_kind    = KIND_ERROR;
          phase_mid = PH_SKIP;
        end else begin
          a_data    = {high_nibble, hex_val};
          phase_mid = PH_PATH;
        end
      end
      PH_QNAME, PH_QVALUE: begin
        if (in_byte == CharAmp) begin
          a_v       = 1'b1;
          a_kind    = KIND_PAIR_END;
          phase_mid = PH_QNAME;
          pair_mid  = 1'b0;
        end else if (in_byte == CharEquals && phase == PH_QNAME) begin
          phase_mid = PH_QVALUE;
          pair_mid  = 1'b1;
        end else begin
          a_v      = 1'b1;
          a_kind   = (phase == PH_QNAME) ? KIND_NAME : KIND_VALUE;
          a_data   = in_byte;
          pair_mid = 1'b1;
        end
      end
      default: begin
        // Skipping after an error: nothing comes out.
      end
    endcase
  end

  // End of the URI: a closing result if one is due, then the state is reset.
  always_comb begin
    b_v    = 1'b0;
    b_kind = KIND_PATH_END;
    if (in_last) begin
      case (phase_mid)
        PH_PATH: begin
          b_v = 1'b1;
        end
        PH_ESC1, PH_ESC2: begin
          b_v    = 1'b1;
          b_kind = KIND_ERROR;
        end
        PH_QNAME, PH_QVALUE: begin
          b_v    = pair_mid;
          b_kind = KIND_PAIR_END;
        end
        default: begin
          b_v = 1'b0;
        end
      endcase
    end
    phase_next = in_last ? PH_PATH : phase_mid;
    nib_next   = in_last ? 4'd0 : nib_mid;
    pair_next  = in_last ? 1'b0 : pair_mid;
  end

  // Order the results: the byte's own result comes first.
  always_comb begin
    res.v0          = a_v | b_v;
    res.v1          = a_v & b_v;
    res.r0.kind     = a_v ? a_kind : b_kind;
    res.r0.data     = a_v ? a_data : 8'h00;
    res.r0.run_last = ~(a_v & b_v);
    res.r1.kind     = b_kind;
    res.r1.data     = 8'h00;
    res.r1.run_last = 1'b1;
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PATH;
      high_nibble <= 4'd0;
      pair_open   <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      high_nibble <= nib_next;
      pair_open   <= pair_next;
    end
  end

  // A final byte always leaves the parser back in the path with no open pair.
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    step && in_last |=> phase == PH_PATH && !pair_open && high_nibble == 4'd0)
    else $error("state not cleared after final byte");

  // A second result is only ever the closing result of a final byte.
  a_second_is_close: assert property (@(posedge clk) disable iff (rst)
    res.v1 |-> in_last && res.v0 && !res.r0.run_last &&
      (res.r1.kind == KIND_PATH_END || res.r1.kind == KIND_PAIR_END))
    else $error("unexpected second result");

  // Once skipping, the parser stays silent, the final byte included.
  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_SKIP |-> !res.v0)
    else $error("result produced while skipping");

  // The held nibble only changes on the first escape digit or at the end.
  a_nibble_hold: assert property (@(posedge clk) disable iff (rst)
    !(step && (phase == PH_ESC1 || in_last)) |=> $stable(high_nibble))
    else $error("escape nibble changed unexpectedly");

endmodule

// ----- rtl/upqs_result_fifo.sv -----
module upqs_result_fifo
  import upqs_pkg::*;
#(
  parameter int DEPTH = ResultDepth
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  step_t   push_res,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  result_t         mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] wr_ptr1;
  logic [PtrW-1:0] wr_ptr2;
  logic [PtrW-1:0] wr_ptr_next;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic [1:0]      push_n;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_incr(input logic [PtrW-1:0] p);
    ptr_incr = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // Occupancy and pointer arithmetic.
  always_comb begin
    push_n = 2'd0;
    if (push) begin
      push_n = {1'b0, push_res.v0} + {1'b0, push_res.v1};
    end
    pop         = out_valid & out_ready;
    wr_ptr1     = ptr_incr(wr_ptr);
    wr_ptr2     = ptr_incr(wr_ptr1);
    wr_ptr_next = (push_n == 2'd2) ? wr_ptr2 : (push_n == 2'd1) ? wr_ptr1 : wr_ptr;
    count_next  = count + CntW'(push_n) - CntW'(pop);
  end

  // Room for the two results a byte may cause, even with no beat leaving.
  assign space     = (count <= CntW'(DEPTH - 2));
  assign out_valid = (count != '0);
  assign head      = mem[rd_ptr];

  // Result storage.
  always_ff @(posedge clk) begin
    if (push && push_res.v0) begin
      mem[wr_ptr] <= push_res.r0;
    end
    if (push && push_res.v1) begin
      mem[wr_ptr1] <= push_res.r1;
    end
  end

  // Queue control.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= ptr_incr(rd_ptr);
      end
    end
  end

  // The queue never overfills.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("result queue overflow");

  // A push only happens when two entries are free.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 |-> space)
    else $error("push without room");

  // A lone pop lowers the count by exactly one.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    pop && push_n == 2'd0 |=> count == $past(count) - CntW'(1))
    else $error("count wrong after pop");

endmodule
